// ----- hdl/ccb_pkg.sv -----
// ----------------------------------------------------------------------------
// ccb_pkg: shared types and constants of the color-key blitter
// Field widths, register indexes, mode codes and the flag group that
// travels from the classify front to the address back.
// ----------------------------------------------------------------------------
package ccb_pkg;

	// fixed field widths
	localparam int PIX_W      = 16;
	localparam int ADDR_W     = 18;
	localparam int SIZE_W     = 10;
	localparam int OFF_W      = 11;
	localparam int KEY_W      = 17;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 3;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_SRC_WIDTH  = 3'd1,
		REG_SRC_HEIGHT = 3'd2,
		REG_DST_WIDTH  = 3'd3,
		REG_DST_HEIGHT = 3'd4,
		REG_X_OFFSET   = 3'd5,
		REG_Y_OFFSET   = 3'd6,
		REG_KEY_COLOR  = 3'd7
	} ccb_reg_t;

	// blit modes
	localparam logic MODE_OVERLAY = 1'b0;
	localparam logic MODE_WINDOW  = 1'b1;

	// key value that disables keying
	localparam logic signed [KEY_W-1:0] KEY_NONE = -17'sd1;

	// per-pixel decision flags
	typedef struct packed {
		logic write_enable;
		logic window_error;
		logic picture_done;
	} ccb_flags_t;

endpackage

// ----- hdl/ccb_if.sv -----
// ----------------------------------------------------------------------------
// ccb_if: valid/ready channels of the color-key blitter
// Source pixel channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface ccb_pix_if import ccb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             first_of_picture;

	modport source(output valid, output pixel_in, output first_of_picture, input ready);
	modport sink(input valid, input pixel_in, input first_of_picture, output ready);
endinterface

interface ccb_res_if import ccb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] dest_address;
	logic [PIX_W-1:0]  pixel_out;
	logic              window_error;
	logic              picture_done;

	modport source(output valid, output write_enable, output dest_address,
		output pixel_out, output window_error, output picture_done, input ready);
	modport sink(input valid, input write_enable, input dest_address,
		input pixel_out, input window_error, input picture_done, output ready);
endinterface

// ----- hdl/ccb_front.sv -----
// ----------------------------------------------------------------------------
// ccb_front: pixel intake and classification
// Keeps the raster counters, maps the source position to the destination
// and decides write, window error and end of picture for each beat.
// ----------------------------------------------------------------------------
module ccb_front import ccb_pkg::*; #(
	parameter int CW   = 9,
	parameter int DIMW = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    mode,
	input  logic [DIMW-1:0]         src_w,
	input  logic [DIMW-1:0]         src_h,
	input  logic [DIMW-1:0]         dst_w,
	input  logic [DIMW-1:0]         dst_h,
	input  logic signed [OFF_W-1:0] x_off,
	input  logic signed [OFF_W-1:0] y_off,
	input  logic signed [KEY_W-1:0] key_color,
	ccb_pix_if.sink                 pixels,
	input  logic                    q_full,
	output logic                    push,
	output ccb_flags_t              push_flags,
	output logic [CW-1:0]           push_dx,
	output logic [CW-1:0]           push_dy,
	output logic [PIX_W-1:0]        push_pix
);

	localparam int PW = ((DIMW > OFF_W) ? DIMW : OFF_W) + 2;

	logic [CW-1:0]          col_q, row_q;
	logic [CW-1:0]          cx, cy;
	logic [DIMW:0]          cx_inc, cy_inc;
	logic                   in_src, done;
	logic signed [PW-1:0]   cx_s, cy_s, xo_s, yo_s;
	logic signed [PW-1:0]   sw_s, sh_s, dw_s, dh_s;
	logic signed [PW-1:0]   dx, dy;
	logic                   in_dst, key_hit, err, we;

	assign pixels.ready = !q_full;
	assign push         = pixels.valid && !q_full;

	// current source position
	assign cx     = pixels.first_of_picture ? '0 : col_q;
	assign cy     = pixels.first_of_picture ? '0 : row_q;
	assign cx_inc = (DIMW+1)'(cx) + (DIMW+1)'(1);
	assign cy_inc = (DIMW+1)'(cy) + (DIMW+1)'(1);
	assign in_src = (DIMW'(cx) < src_w) && (DIMW'(cy) < src_h);
	assign done   = (DIMW'(cx) == src_w - DIMW'(1)) && (DIMW'(cy) == src_h - DIMW'(1));

	// signed views for the offset arithmetic
	assign cx_s = $signed(PW'(cx));
	assign cy_s = $signed(PW'(cy));
	assign xo_s = PW'(x_off);
	assign yo_s = PW'(y_off);
	assign sw_s = $signed(PW'(src_w));
	assign sh_s = $signed(PW'(src_h));
	assign dw_s = $signed(PW'(dst_w));
	assign dh_s = $signed(PW'(dst_h));

	// destination position: added in overlay, subtracted in window copy
	assign dx = (mode == MODE_WINDOW) ? (cx_s - xo_s) : (cx_s + xo_s);
	assign dy = (mode == MODE_WINDOW) ? (cy_s - yo_s) : (cy_s + yo_s);

	assign in_dst = (dx >= 0) && (dy >= 0) && (dx < dw_s) && (dy < dh_s);

	// key match, the no-key value never equals a pixel
	assign key_hit = (key_color == $signed({1'b0, pixels.pixel_in}));

	// window must fit inside the source
	assign err = (mode == MODE_WINDOW) &&
		((x_off < 0) || (y_off < 0) || (dw_s + xo_s > sw_s) || (dh_s + yo_s > sh_s));

	// write decision
	always_comb begin
		if (mode == MODE_WINDOW) begin
			we = in_src && in_dst && !err;
		end else begin
			we = in_src && in_dst && !key_hit;
		end
	end

	assign push_flags.write_enable = we;
	assign push_flags.window_error = err;
	assign push_flags.picture_done = done;
	assign push_dx  = CW'(dx);
	assign push_dy  = CW'(dy);
	assign push_pix = pixels.pixel_in;

	// raster counters advance on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (cx_inc >= {1'b0, src_w}) begin
				col_q <= '0;
				row_q <= (cy_inc >= {1'b0, src_h}) ? '0 : CW'(cy_inc);
			end else begin
				col_q <= CW'(cx_inc);
				row_q <= (DIMW'(cy) >= src_h) ? '0 : cy;
			end
		end
	end

endmodule

// ----- hdl/ccb_fifo.sv -----
// ----------------------------------------------------------------------------
// ccb_fifo: short decision queue
// Register-based queue between the classify front and the address back.
// ----------------------------------------------------------------------------
module ccb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ----- hdl/ccb_back.sv -----
// ----------------------------------------------------------------------------
// ccb_back: address generation and result register
// Turns a queued decision into a linear destination address and holds the
// result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ccb_back import ccb_pkg::*; #(
	parameter int CW   = 9,
	parameter int DIMW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIMW-1:0]  dst_w,
	input  logic             q_empty,
	output logic             pop,
	input  ccb_flags_t       pop_flags,
	input  logic [CW-1:0]    pop_dx,
	input  logic [CW-1:0]    pop_dy,
	input  logic [PIX_W-1:0] pop_pix,
	ccb_res_if.source        results
);

	localparam int LW = CW + DIMW + 1;

	logic              valid_q;
	ccb_flags_t        flags_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PIX_W-1:0]  pix_q;
	logic [LW-1:0]     lin;

	// row times width plus column
	assign lin = LW'(pop_dy) * LW'(dst_w) + LW'(pop_dx);

	assign pop = !q_empty && (!valid_q || results.ready);

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || results.ready) begin
			valid_q <= !q_empty;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			flags_q <= pop_flags;
			addr_q  <= pop_flags.write_enable ? ADDR_W'(lin) : '0;
			pix_q   <= pop_pix;
		end
	end

	assign results.valid        = valid_q;
	assign results.write_enable = flags_q.write_enable;
	assign results.dest_address = addr_q;
	assign results.pixel_out    = pix_q;
	assign results.window_error = flags_q.window_error;
	assign results.picture_done = flags_q.picture_done;

endmodule

// ----- hdl/clip_colorkey_blitter.sv -----
// path: an accepted pixel beat passes the decision queue, then the result register
// throughput: one pixel per cycle; the front stalls only when the two-entry
//   decision queue is full, which needs the result sink to hold ready low
// address multiply sits alone in the back stage, one per cycle unless the result sink stalls
// reset: raster counters, queue and result valid clear; registers return to
//   overlay mode, sizes 1, offsets 0 and no key
// ----------------------------------------------------------------------------
// clip_colorkey_blitter: color-key blitter with clipping
// Classifying front, decision queue and address back, plus the register file.
// ----------------------------------------------------------------------------
module clip_colorkey_blitter import ccb_pkg::*; #(
	parameter int MAX_DIM = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ccb_pix_if.sink              pixels,
	ccb_res_if.source            results
);

	localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIMW = $clog2(MAX_DIM + 1);
	localparam int EW   = $bits(ccb_flags_t) + 2 * CW + PIX_W;

	logic                    mode_q;
	logic [DIMW-1:0]         src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic signed [OFF_W-1:0] x_off_q, y_off_q;
	logic signed [KEY_W-1:0] key_q;
	logic [SIZE_W-1:0]       size_raw;
	logic [DIMW-1:0]         size_clamped;

	logic             push, pop, q_full, q_empty;
	ccb_flags_t       push_flags, pop_flags;
	logic [CW-1:0]    push_dx, push_dy, pop_dx, pop_dy;
	logic [PIX_W-1:0] push_pix, pop_pix;
	logic [EW-1:0]    push_data, pop_data;

	// size clamp to 1..MAX_DIM
	assign size_raw = cfg_data[SIZE_W-1:0];
	always_comb begin
		if (size_raw == '0) begin
			size_clamped = DIMW'(1);
		end else if (int'(size_raw) > MAX_DIM) begin
			size_clamped = DIMW'(MAX_DIM);
		end else begin
			size_clamped = DIMW'(size_raw);
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OVERLAY;
			src_w_q <= DIMW'(1);
			src_h_q <= DIMW'(1);
			dst_w_q <= DIMW'(1);
			dst_h_q <= DIMW'(1);
			x_off_q <= '0;
			y_off_q <= '0;
			key_q   <= KEY_NONE;
		end else if (cfg_write) begin
			case (ccb_reg_t'(cfg_index))
				REG_MODE:       mode_q  <= cfg_data[0];
				REG_SRC_WIDTH:  src_w_q <= size_clamped;
				REG_SRC_HEIGHT: src_h_q <= size_clamped;
				REG_DST_WIDTH:  dst_w_q <= size_clamped;
				REG_DST_HEIGHT: dst_h_q <= size_clamped;
				REG_X_OFFSET:   x_off_q <= $signed(cfg_data[OFF_W-1:0]);
				REG_Y_OFFSET:   y_off_q <= $signed(cfg_data[OFF_W-1:0]);
				REG_KEY_COLOR:  key_q   <= $signed(cfg_data[KEY_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// classify front
	ccb_front #(.CW(CW), .DIMW(DIMW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.src_w      (src_w_q),
		.src_h      (src_h_q),
		.dst_w      (dst_w_q),
		.dst_h      (dst_h_q),
		.x_off      (x_off_q),
		.y_off      (y_off_q),
		.key_color  (key_q),
		.pixels     (pixels),
		.q_full     (q_full),
		.push       (push),
		.push_flags (push_flags),
		.push_dx    (push_dx),
		.push_dy    (push_dy),
		.push_pix   (push_pix)
	);

	// decision queue
	assign push_data = {push_flags, push_dx, push_dy, push_pix};
	assign {pop_flags, pop_dx, pop_dy, pop_pix} = pop_data;

	ccb_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// address back
	ccb_back #(.CW(CW), .DIMW(DIMW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dst_w     (dst_w_q),
		.q_empty   (q_empty),
		.pop       (pop),
		.pop_flags (pop_flags),
		.pop_dx    (pop_dx),
		.pop_dy    (pop_dy),
		.pop_pix   (pop_pix),
		.results   (results)
	);

endmodule

// ----- hdl/ccb_checker.sv -----
// ----------------------------------------------------------------------------
// ccb_checker: port-level checks of the color-key blitter
// Watches the configuration port and the result channel.
// ----------------------------------------------------------------------------
module ccb_checker import ccb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 res_write_enable,
	input logic [ADDR_W-1:0]    res_dest_address,
	input logic                 res_window_error
);

	logic mode_q;

	// shadow of the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OVERLAY;
		end else if (cfg_write && (cfg_index == REG_MODE)) begin
			mode_q <= cfg_data[0];
		end
	end

	// skipped pixels carry a zero address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_write_enable) |-> (res_dest_address == '0))
		else $error("dest_address nonzero without write_enable");

	// a window error suppresses the write
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_window_error) |-> !res_write_enable)
		else $error("write_enable with window_error");

	// overlay mode never reports a window error
	a_overlay_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (mode_q == MODE_OVERLAY)) |-> !res_window_error)
		else $error("window_error in overlay mode");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
		(res_valid && $stable(res_dest_address) && $stable(res_write_enable)))
		else $error("result beat changed while stalled");

endmodule

bind clip_colorkey_blitter ccb_checker u_ccb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_write        (cfg_write),
	.cfg_index        (cfg_index),
	.cfg_data         (cfg_data),
	.res_valid        (results.valid),
	.res_ready        (results.ready),
	.res_write_enable (results.write_enable),
	.res_dest_address (results.dest_address),
	.res_window_error (results.window_error)
);

// ----- test/blit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_checker: scoreboard for the color-key blitter
// Mirrors the register writes and the raster counters, predicts the write
// decision, address and flags of every accepted pixel beat, and compares
// each result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module blit_checker import ccb_pkg::*; #(
	parameter int MAX_DIM = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ccb_pix_if                   pixels,
	ccb_res_if                   results,
	output int                   fails,
	output int                   pending,
	output int                   pixel_beats,
	output int                   written,
	output int                   window_errors,
	output int                   pictures_done
);

	localparam int REPORT_MAX = 20;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] dest_address;
		logic [PIX_W-1:0]  pixel_out;
		logic              window_error;
		logic              picture_done;
	} blit_result_t;

	// mirrored registers
	logic                     blit_mode;
	logic [SIZE_W-1:0]        src_w, src_h, dst_w, dst_h;
	logic signed [OFF_W-1:0]  x_off, y_off;
	logic signed [KEY_W-1:0]  key;

	// raster position of the next pixel
	int col, row;

	blit_result_t placed_q[$];
	blit_result_t want;
	int fail_count, beat_count, write_count, error_count, done_count;

	function automatic int fit_dim(input logic [SIZE_W-1:0] v);
		if (v == '0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	// decide where one source pixel lands and step the raster counters
	function automatic blit_result_t place_pixel(input logic [PIX_W-1:0] pix, input logic first);
		int sw, sh, dw, dh, cx, cy, dx, dy;
		logic in_src;
		blit_result_t r;
		sw = fit_dim(src_w);
		sh = fit_dim(src_h);
		dw = fit_dim(dst_w);
		dh = fit_dim(dst_h);
		if (first) begin
			col = 0;
			row = 0;
		end
		cx = col;
		cy = row;
		in_src = (cx < sw) && (cy < sh);
		r = '0;
		r.pixel_out = pix;
		r.picture_done = (cx == sw - 1) && (cy == sh - 1);
		if (blit_mode == MODE_OVERLAY) begin
			dx = cx + int'(x_off);
			dy = cy + int'(y_off);
			r.write_enable = in_src && dx >= 0 && dy >= 0 && dx < dw && dy < dh &&
				int'(pix) != int'(key);
		end else begin
			r.window_error = int'(x_off) < 0 || int'(y_off) < 0 ||
				dw + int'(x_off) > sw || dh + int'(y_off) > sh;
			dx = cx - int'(x_off);
			dy = cy - int'(y_off);
			r.write_enable = !r.window_error && in_src && dx >= 0 && dy >= 0 &&
				dx < dw && dy < dh;
		end
		if (r.write_enable)
			r.dest_address = ADDR_W'(dy * dw + dx);
		// wrap at the end of a row and of the picture
		if (cx + 1 >= sw) begin
			col = 0;
			row = (cy + 1 >= sh) ? 0 : cy + 1;
		end else begin
			col = cx + 1;
			row = (cy >= sh) ? 0 : cy;
		end
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v === got_v) return 0;
		if (fail_count < REPORT_MAX)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blit_mode = MODE_OVERLAY;
			src_w = 1;
			src_h = 1;
			dst_w = 1;
			dst_h = 1;
			x_off = '0;
			y_off = '0;
			key = KEY_NONE;
			col = 0;
			row = 0;
			placed_q.delete();
			fail_count = 0;
			beat_count = 0;
			write_count = 0;
			error_count = 0;
			done_count = 0;
			fails <= 0;
			pending <= 0;
			pixel_beats <= 0;
			written <= 0;
			window_errors <= 0;
			pictures_done <= 0;
		end else begin
			// result beat against the oldest prediction
			if (results.valid && results.ready) begin
				if (placed_q.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: result beat with no pixel outstanding, expected none, actual addr %0d",
							$time, results.dest_address);
					fail_count++;
				end else begin
					want = placed_q.pop_front();
					fail_count += field_diff("write_enable", want.write_enable, results.write_enable)
						+ field_diff("dest_address", want.dest_address, results.dest_address)
						+ field_diff("pixel_out", want.pixel_out, results.pixel_out)
						+ field_diff("window_error", want.window_error, results.window_error)
						+ field_diff("picture_done", want.picture_done, results.picture_done);
				end
			end

			// predict each accepted pixel beat
			if (pixels.valid && pixels.ready) begin
				want = place_pixel(pixels.pixel_in, pixels.first_of_picture);
				placed_q.push_back(want);
				beat_count++;
				write_count += want.write_enable;
				error_count += want.window_error;
				done_count += want.picture_done;
			end

			// register writes
			if (cfg_write) begin
				case (ccb_reg_t'(cfg_index))
					REG_MODE:       blit_mode = cfg_data[0];
					REG_SRC_WIDTH:  src_w = cfg_data[SIZE_W-1:0];
					REG_SRC_HEIGHT: src_h = cfg_data[SIZE_W-1:0];
					REG_DST_WIDTH:  dst_w = cfg_data[SIZE_W-1:0];
					REG_DST_HEIGHT: dst_h = cfg_data[SIZE_W-1:0];
					REG_X_OFFSET:   x_off = cfg_data[OFF_W-1:0];
					REG_Y_OFFSET:   y_off = cfg_data[OFF_W-1:0];
					REG_KEY_COLOR:  key = cfg_data[KEY_W-1:0];
				endcase
			end

			fails <= fail_count;
			pending <= placed_q.size();
			pixel_beats <= beat_count;
			written <= write_count;
			window_errors <= error_count;
			pictures_done <= done_count;
		end
	end

endmodule

// ----- test/clip_colorkey_blitter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_colorkey_blitter_test: testbench top of the color-key blitter
// Drives register settings and pixel streams in both modes with random gaps
// and result stalls, including one long result hold-off; the scoreboard
// beside the block checks every result beat.
// ----------------------------------------------------------------------------
module clip_colorkey_blitter_test;
	import ccb_pkg::*;

	localparam int ITEMS       = 1450;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF    = 200;
	localparam int TAIL        = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ccb_pix_if pixels();
	ccb_res_if results();

	int  fails, pending, pixel_beats, written, window_errors, pictures_done;
	int  items, settings;
	int  cur_sw, cur_sh, cur_key;
	bit  calm, held;

	clip_colorkey_blitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixels),
		.results   (results)
	);

	blit_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixels        (pixels),
		.results       (results),
		.fails         (fails),
		.pending       (pending),
		.pixel_beats   (pixel_beats),
		.written       (written),
		.window_errors (window_errors),
		.pictures_done (pictures_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int fit(input int v);
		if (v < 1) return 1;
		if (v > 512) return 512;
		return v;
	endfunction

	function automatic int rand_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(512, 1023);
		return $urandom_range(1, 8);
	endfunction

	function automatic int rand_offset();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return -512;
		if (r == 1) return 512;
		if (r < 5) return $urandom_range(0, 1024) - 512;
		return $urandom_range(0, 8) - 4;
	endfunction

	task automatic write_reg(input ccb_reg_t idx, input int val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
	endtask

	// full register set, written while the block is idle
	task automatic setup(input int m, input int sw, input int sh, input int dw, input int dh,
		input int xo, input int yo, input int key);
		write_reg(REG_MODE, m);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_OFFSET, yo);
		write_reg(REG_KEY_COLOR, key);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_sw = sw;
		cur_sh = sh;
		cur_key = key;
		settings++;
	endtask

	// one pixel beat, held until accepted
	task automatic send_beat(input logic [PIX_W-1:0] pix, input logic first);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			pixels.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.pixel_in <= pix;
		pixels.first_of_picture <= first;
		do @(posedge clk); while (!pixels.ready);
		items++;
	endtask

	// let the scoreboard count the last beat before waiting for it to drain
	task automatic end_phase();
		pixels.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic send_picture(input int count, input int at, input logic [PIX_W-1:0] special);
		for (int i = 0; i < count; i++)
			send_beat(i == at ? special : PIX_W'($urandom), i == 0);
		end_phase();
	endtask

	// pictures with random content, mostly framed, some broken
	task automatic run_phase(input int count, input bit mark_start);
		int pos;
		int plen;
		bit first;
		logic [PIX_W-1:0] pix;
		plen = fit(cur_sw) * fit(cur_sh);
		pos = 0;
		for (int i = 0; i < count; i++) begin
			if (i == 0)
				first = mark_start;
			else if (pos == 0)
				first = ($urandom_range(0, 9) != 0);
			else
				first = ($urandom_range(0, 39) == 0);
			if (first)
				pos = 0;
			case ($urandom_range(0, 9))
				0, 1, 2: pix = (cur_key >= 0 && cur_key <= 65535) ? PIX_W'(cur_key) : PIX_W'($urandom);
				3:       pix = '0;
				4:       pix = '1;
				default: pix = PIX_W'($urandom);
			endcase
			send_beat(pix, first);
			pos = (pos + 1) % plen;
		end
		end_phase();
	endtask

	// result sink: random ready, one long hold-off while pixels are offered
	initial begin : result_sink
		int run;
		forever begin
			if (!held && pixel_beats >= 300 && pixels.valid) begin
				held = 1'b1;
				results.ready <= 1'b0;
				run = HOLD_OFF;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				results.ready <= 1'b1;
				run = $urandom_range(1, 12);
			end else begin
				results.ready <= 1'b0;
				run = pick_gap();
				if (run == 0)
					run = 1;
			end
			repeat (run) @(posedge clk);
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((pixels.valid && pixels.ready) || (results.valid && results.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL clip_colorkey_blitter");
		$finish;
	end

	// stimulus
	initial begin
		int m, sw, sh, dw, dh, xo, yo, key, r;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		pixels.valid <= 1'b0;
		pixels.pixel_in <= '0;
		pixels.first_of_picture <= 1'b0;
		cur_sw = 1;
		cur_sh = 1;
		cur_key = -1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every pixel is a whole picture written at address 0
		send_picture(3, 1, 16'hFFFF);
		// overlay with left and bottom clipping and a key hit
		setup(MODE_OVERLAY, 4, 2, 2, 2, -1, 1, 'h1234);
		send_picture(8, 2, 16'h1234);
		// window copy; the key has no effect here
		setup(MODE_WINDOW, 4, 3, 2, 2, 1, 1, 'h1234);
		send_picture(12, 5, 16'h1234);
		// window that runs past the right edge of the source
		setup(MODE_WINDOW, 4, 3, 4, 2, 1, 0, -1);
		send_picture(2, 0, 16'h0000);

		items = 0;
		while (items < ITEMS) begin
			calm = (settings % 4 == 3);
			if (settings == 8) begin
				// widest source row into the last destination row, key at the top value
				setup(MODE_OVERLAY, 1023, 0, 1023, 512, 0, 511, 65535);
				run_phase(520, 1'b1);
			end else begin
				m = $urandom_range(0, 1);
				sw = rand_dim();
				sh = rand_dim();
				if (m == MODE_WINDOW && $urandom_range(0, 4) != 0) begin
					xo = $urandom_range(0, fit(sw) - 1);
					yo = $urandom_range(0, fit(sh) - 1);
					dw = $urandom_range(1, fit(sw) - xo);
					dh = $urandom_range(1, fit(sh) - yo);
				end else begin
					dw = rand_dim();
					dh = rand_dim();
					xo = rand_offset();
					yo = rand_offset();
				end
				r = $urandom_range(0, 9);
				if (r < 2)
					key = -1;
				else if (r == 2)
					key = -int'($urandom_range(2, 65536));
				else if (r == 3)
					key = 0;
				else if (r == 4)
					key = 65535;
				else
					key = $urandom_range(0, 65535);
				setup(m, sw, sh, dw, dh, xo, yo, key);
				run_phase($urandom_range(15, 50), $urandom_range(0, 3) != 0);
			end
		end
		calm = 1'b0;

		$display("run covered %0d pixel beats over %0d register settings in both modes",
			pixel_beats, settings);
		$display("%0d writes, %0d window errors, %0d pictures ended, long result hold-off %s",
			written, window_errors, pictures_done, held ? "done" : "not reached");
		if (fails == 0 && pending == 0)
			$display("PASS clip_colorkey_blitter");
		else
			$display("FAIL clip_colorkey_blitter");
		$finish;
	end

endmodule
